>>> rtl/core/pmst_pkg.sv
// Shared constants, controller states and command types for the Prim spanning tree block.
`default_nettype none

package pmst_pkg;

    localparam int DEF_MAX_NODES = 64;
    localparam int CFG_W         = 7;
    localparam int DIST_W        = 32;

    localparam logic [DIST_W-1:0] NO_DIST = '1;

    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT,
        S_PREV,
        S_RD,
        S_ST,
        S_CMP,
        S_SWP_RD,
        S_SWP_W1,
        S_SWP_W2,
        S_MAP_RD,
        S_MAP_WR,
        S_OUT_RD,
        S_OUT_WR
    } t_state;

    typedef struct packed {
        logic load_wr;
        logic init_wr;
        logic rd_a;
        logic cap_prev;
        logic st_rd;
        logic cmp;
        logic first;
        logic swp_rd;
        logic swp_w1;
        logic swp_w2;
        logic map_wr;
        logic out_rd;
        logic out_ld;
        logic out_last;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

>>> rtl/core/pmst_ctrl.sv
// Controller state machine that sequences loading, the Prim scan, the swap and the result sweep.
`default_nettype none

module pmst_ctrl #(
    parameter int MAX_NODES = pmst_pkg::DEF_MAX_NODES
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire                                i_cfg_wr_en,
    input  wire  [pmst_pkg::CFG_W-1:0]         i_cfg_wr_data,
    input  pmst_pkg::t_sts                     i_sts,
    output pmst_pkg::t_cmd                     o_cmd,
    output logic [$clog2(MAX_NODES)-1:0]       o_idx,
    output logic [$clog2(MAX_NODES*MAX_NODES)-1:0] o_ld_addr,
    output logic [$clog2(MAX_NODES+1)-1:0]     o_n
);

    localparam int IW = $clog2(MAX_NODES);
    localparam int NW = $clog2(MAX_NODES + 1);
    localparam int AW = $clog2(MAX_NODES * MAX_NODES);

    pmst_pkg::t_state r_state, n_state;
    logic [IW-1:0]    r_i, n_i;
    logic [IW-1:0]    r_p, n_p;
    logic [AW-1:0]    r_ld, n_ld;
    logic [NW-1:0]    r_n, n_n;

    logic [2*NW-1:0]  w_total;
    logic [AW-1:0]    w_last_pos;
    logic [IW-1:0]    w_nm1;

    assign w_total    = (2*NW)'(r_n) * (2*NW)'(r_n);
    assign w_last_pos = AW'(w_total - (2*NW)'(1));
    assign w_nm1      = IW'(r_n - NW'(1));
    assign o_ld_addr  = r_ld;
    assign o_n        = r_n;

    always_comb begin
        if (i_cfg_wr_data == pmst_pkg::CFG_W'(0)) begin
            n_n = NW'(1);
        end else if (i_cfg_wr_data > pmst_pkg::CFG_W'(MAX_NODES)) begin
            n_n = NW'(MAX_NODES);
        end else begin
            n_n = NW'(i_cfg_wr_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pmst_pkg::S_LOAD;
            r_i     <= '0;
            r_p     <= '0;
            r_ld    <= '0;
            r_n     <= NW'(MAX_NODES);
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_p     <= n_p;
            r_ld    <= n_ld;
            if (i_cfg_wr_en) begin
                r_n <= n_n;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_p     = r_p;
        n_ld    = r_ld;
        o_cmd   = '0;
        o_idx   = r_i;
        o_ready = 1'b0;
        case (r_state)
            pmst_pkg::S_LOAD: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_wr = 1'b1;
                    if (r_ld == w_last_pos) begin
                        n_ld    = '0;
                        n_i     = '0;
                        n_state = pmst_pkg::S_INIT;
                    end else begin
                        n_ld = r_ld + AW'(1);
                    end
                end
            end
            pmst_pkg::S_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (r_i == w_nm1) begin
                    n_i = '0;
                    if (r_n == NW'(1)) begin
                        n_state = pmst_pkg::S_MAP_RD;
                    end else begin
                        n_p     = IW'(1);
                        n_state = pmst_pkg::S_PREV;
                    end
                end else begin
                    n_i = r_i + IW'(1);
                end
            end
            pmst_pkg::S_PREV: begin
                o_idx      = r_p - IW'(1);
                o_cmd.rd_a = 1'b1;
                n_i        = r_p;
                n_state    = pmst_pkg::S_RD;
            end
            pmst_pkg::S_RD: begin
                o_cmd.rd_a     = 1'b1;
                o_cmd.cap_prev = (r_i == r_p);
                n_state        = pmst_pkg::S_ST;
            end
            pmst_pkg::S_ST: begin
                o_cmd.st_rd = 1'b1;
                n_state     = pmst_pkg::S_CMP;
            end
            pmst_pkg::S_CMP: begin
                o_cmd.cmp   = 1'b1;
                o_cmd.first = (r_i == r_p);
                if (r_i == w_nm1) begin
                    n_state = pmst_pkg::S_SWP_RD;
                end else begin
                    n_i     = r_i + IW'(1);
                    n_state = pmst_pkg::S_RD;
                end
            end
            pmst_pkg::S_SWP_RD: begin
                o_idx        = r_p;
                o_cmd.swp_rd = 1'b1;
                n_state      = pmst_pkg::S_SWP_W1;
            end
            pmst_pkg::S_SWP_W1: begin
                o_idx        = r_p;
                o_cmd.swp_w1 = 1'b1;
                n_state      = pmst_pkg::S_SWP_W2;
            end
            pmst_pkg::S_SWP_W2: begin
                o_cmd.swp_w2 = 1'b1;
                if (r_p == w_nm1) begin
                    n_i     = '0;
                    n_state = pmst_pkg::S_MAP_RD;
                end else begin
                    n_p     = r_p + IW'(1);
                    n_state = pmst_pkg::S_PREV;
                end
            end
            pmst_pkg::S_MAP_RD: begin
                o_cmd.rd_a = 1'b1;
                n_state    = pmst_pkg::S_MAP_WR;
            end
            pmst_pkg::S_MAP_WR: begin
                o_cmd.map_wr = 1'b1;
                if (r_i == w_nm1) begin
                    n_i     = '0;
                    n_state = pmst_pkg::S_OUT_RD;
                end else begin
                    n_i     = r_i + IW'(1);
                    n_state = pmst_pkg::S_MAP_RD;
                end
            end
            pmst_pkg::S_OUT_RD: begin
                o_cmd.out_rd = 1'b1;
                n_state      = pmst_pkg::S_OUT_WR;
            end
            pmst_pkg::S_OUT_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_last = (r_i == w_nm1);
                    if (r_i == w_nm1) begin
                        n_state = pmst_pkg::S_LOAD;
                    end else begin
                        n_i     = r_i + IW'(1);
                        n_state = pmst_pkg::S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = pmst_pkg::S_LOAD;
            end
        endcase
        if (i_cfg_wr_en) begin
            n_ld = '0;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/pmst_dp.sv
// Datapath with the distance memory, the working order memories, the compare and the output register.
`default_nettype none

module pmst_dp #(
    parameter int MAX_NODES = pmst_pkg::DEF_MAX_NODES
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  pmst_pkg::t_cmd                         i_cmd,
    output pmst_pkg::t_sts                         o_sts,
    input  wire  [$clog2(MAX_NODES)-1:0]           i_idx,
    input  wire  [$clog2(MAX_NODES*MAX_NODES)-1:0] i_ld_addr,
    input  wire  [$clog2(MAX_NODES+1)-1:0]         i_n,
    input  wire  [pmst_pkg::DIST_W-1:0]            i_distance,
    output logic                                   o_valid,
    input  wire                                    i_ready,
    output logic [$clog2(MAX_NODES)-1:0]           o_child,
    output logic [$clog2(MAX_NODES)-1:0]           o_parent,
    output logic                                   o_last_of_run
);

    localparam int IW = $clog2(MAX_NODES);
    localparam int NW = $clog2(MAX_NODES + 1);
    localparam int AW = $clog2(MAX_NODES * MAX_NODES);
    localparam int DW = pmst_pkg::DIST_W;

    logic [DW-1:0] r_store [MAX_NODES*MAX_NODES];
    logic [IW-1:0] r_wo    [MAX_NODES];
    logic [DW-1:0] r_bd    [MAX_NODES];
    logic [IW-1:0] r_bp    [MAX_NODES];
    logic [IW-1:0] r_par   [MAX_NODES];

    logic [IW-1:0] r_a_wo, r_a_bp, r_b_wo, r_b_bp;
    logic [DW-1:0] r_a_bd, r_b_bd;
    logic [DW-1:0] r_st_q;
    logic [IW-1:0] r_par_q;
    logic [IW-1:0] r_prev;
    logic [DW-1:0] r_min_d;
    logic [IW-1:0] r_min_i;
    logic          r_o_valid;
    logic [IW-1:0] r_o_child, r_o_parent;
    logic          r_o_last;

    logic [IW+NW-1:0] w_prod;
    logic [AW-1:0]    w_st_addr;
    logic             w_lt;
    logic [DW-1:0]    w_new_bd;
    logic             w_rd_a;
    logic             w_we_wo, w_we_bd, w_we_bp;
    logic [IW-1:0]    w_waddr;
    logic [IW-1:0]    w_wo_d, w_bp_d;
    logic [DW-1:0]    w_bd_d;

    assign w_prod    = (IW+NW)'(r_a_wo) * (IW+NW)'(i_n);
    assign w_st_addr = AW'(w_prod + (IW+NW)'(r_prev));
    assign w_lt      = r_st_q < r_a_bd;
    assign w_new_bd  = w_lt ? r_st_q : r_a_bd;
    assign w_rd_a    = i_cmd.rd_a | i_cmd.swp_rd;

    always_comb begin
        w_we_wo = 1'b0;
        w_we_bd = 1'b0;
        w_we_bp = 1'b0;
        w_waddr = i_idx;
        w_wo_d  = r_b_wo;
        w_bd_d  = r_b_bd;
        w_bp_d  = r_b_bp;
        if (i_cmd.init_wr) begin
            w_we_wo = 1'b1;
            w_we_bd = 1'b1;
            w_we_bp = 1'b1;
            w_wo_d  = i_idx;
            w_bd_d  = pmst_pkg::NO_DIST;
            w_bp_d  = '0;
        end else if (i_cmd.cmp) begin
            w_we_bd = w_lt;
            w_we_bp = w_lt;
            w_bd_d  = r_st_q;
            w_bp_d  = r_prev;
        end else if (i_cmd.swp_w1) begin
            w_we_wo = 1'b1;
            w_we_bd = 1'b1;
            w_we_bp = 1'b1;
        end else if (i_cmd.swp_w2) begin
            w_we_wo = 1'b1;
            w_we_bd = 1'b1;
            w_we_bp = 1'b1;
            w_waddr = r_min_i;
            w_wo_d  = r_a_wo;
            w_bd_d  = r_a_bd;
            w_bp_d  = r_a_bp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            r_store[i_ld_addr] <= i_distance;
        end
        if (i_cmd.st_rd) begin
            r_st_q <= r_store[w_st_addr];
        end
        if (w_we_wo) begin
            r_wo[w_waddr] <= w_wo_d;
        end
        if (w_we_bd) begin
            r_bd[w_waddr] <= w_bd_d;
        end
        if (w_we_bp) begin
            r_bp[w_waddr] <= w_bp_d;
        end
        if (w_rd_a) begin
            r_a_wo <= r_wo[i_idx];
            r_a_bd <= r_bd[i_idx];
            r_a_bp <= r_bp[i_idx];
        end
        if (i_cmd.swp_rd) begin
            r_b_wo <= r_wo[r_min_i];
            r_b_bd <= r_bd[r_min_i];
            r_b_bp <= r_bp[r_min_i];
        end
        if (i_cmd.map_wr) begin
            r_par[r_a_wo] <= r_a_bp;
        end
        if (i_cmd.out_rd) begin
            r_par_q <= r_par[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_prev) begin
            r_prev <= r_a_wo;
        end
        if (i_cmd.cmp && (i_cmd.first || (w_new_bd < r_min_d))) begin
            r_min_d <= w_new_bd;
            r_min_i <= i_idx;
        end
        if (i_cmd.out_ld) begin
            r_o_child  <= i_idx;
            r_o_parent <= r_par_q;
            r_o_last   <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_sts.out_free = !r_o_valid || i_ready;
    assign o_valid        = r_o_valid;
    assign o_child        = r_o_child;
    assign o_parent       = r_o_parent;
    assign o_last_of_run  = r_o_last;

endmodule

`default_nettype wire

>>> rtl/core/prim_mst_from_distance_matrix.sv
// Top level of the dense Prim minimum spanning tree block over a loaded distance matrix.
`default_nettype none

// The block takes an n by n distance matrix, one entry per item in row-major order (row is the
// child, column the parent), at one item per cycle. After the last entry it stops taking items,
// builds the tree rooted at node 0 and then returns one item per node, child 0 to n-1, with
// last_of_run set on the final one. The build first sets up the working order, then for each
// added node p (1 to n-1) it sends every candidate through a read of the order memories, a
// read of the distance memory and a compare and write; it then inverts the order and returns
// the results. Writing node_count restarts the matrix load; a value of 0 acts as 1 and a value
// above MAX_NODES as MAX_NODES.
module prim_mst_from_distance_matrix #(
    parameter int MAX_NODES = pmst_pkg::DEF_MAX_NODES
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    output logic                           o_ready,
    input  wire  [pmst_pkg::DIST_W-1:0]    i_distance,
    output logic                           o_valid,
    input  wire                            i_ready,
    output logic [$clog2(MAX_NODES)-1:0]   o_child,
    output logic [$clog2(MAX_NODES)-1:0]   o_parent,
    output logic                           o_last_of_run,
    input  wire                            i_cfg_wr_en,
    input  wire  [pmst_pkg::CFG_W-1:0]     i_cfg_wr_data
);

    localparam int IW = $clog2(MAX_NODES);
    localparam int NW = $clog2(MAX_NODES + 1);
    localparam int AW = $clog2(MAX_NODES * MAX_NODES);

    pmst_pkg::t_cmd w_cmd;
    pmst_pkg::t_sts w_sts;
    logic [IW-1:0]  w_idx;
    logic [AW-1:0]  w_ld_addr;
    logic [NW-1:0]  w_n;
    logic [IW-1:0]  w_nm1;

    assign w_nm1 = IW'(w_n - NW'(1));

    pmst_ctrl #(
        .MAX_NODES(MAX_NODES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd),
        .o_idx        (w_idx),
        .o_ld_addr    (w_ld_addr),
        .o_n          (w_n)
    );

    pmst_dp #(
        .MAX_NODES(MAX_NODES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_idx        (w_idx),
        .i_ld_addr    (w_ld_addr),
        .i_n          (w_n),
        .i_distance   (i_distance),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_child      (o_child),
        .o_parent     (o_parent),
        .o_last_of_run(o_last_of_run)
    );

    // A new result never overwrites one that is still waiting.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_ld |-> (!o_valid || i_ready))
        else $error("result register overwritten");

    // The final item of a tree belongs to the highest node.
    a_last_child: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_of_run) |-> (o_child == w_nm1))
        else $error("last_of_run on wrong child");

    // The root always reports parent zero.
    a_root_parent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_child == '0)) |-> (o_parent == '0))
        else $error("root reports nonzero parent");

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the Prim spanning tree block: distance matrices in, parent items checked.
module tb;
    import pmst_pkg::*;

    localparam int MAX_NODES     = DEF_MAX_NODES;
    localparam int NODE_W        = $clog2(MAX_NODES);
    localparam int STORE_DEPTH   = MAX_NODES * MAX_NODES;
    localparam int SETTLE_CYCLES = 20;
    localparam int LONG_HOLD     = 300;
    localparam int TAIL_CYCLES   = 64;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_ITEMS  = 380;

    typedef enum logic {FEED_DIST, FEED_CFG} feed_kind_t;

    typedef struct {
        feed_kind_t        kind;
        logic [DIST_W-1:0] value;
    } feed_item_t;

    typedef struct {
        logic [NODE_W-1:0] child;
        logic [NODE_W-1:0] parent;
        logic              last;
    } tree_edge_t;

    typedef enum {MIX_FULL, MIX_TIES, MIX_SPARSE, MIX_HIGH} dist_mix_t;
    typedef enum {RX_OPEN, RX_HALF, RX_SPARSE} rx_mode_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [DIST_W-1:0] i_distance = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [NODE_W-1:0] o_child;
    logic [NODE_W-1:0] o_parent;
    logic              o_last_of_run;
    logic              i_cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]  i_cfg_wr_data = '0;

    feed_item_t        feed_q[$];
    tree_edge_t        tree_expect_q[$];

    logic [DIST_W-1:0] matrix_mem [0:STORE_DEPTH-1];
    logic [CFG_W-1:0]  node_cfg = CFG_W'(MAX_NODES);
    int                fill_pos = 0;

    logic              item_taken = 1'b0;
    int                quiet_cnt = 0;
    int                burst_left = 1;
    int                gap_left = 0;
    feed_item_t        feed_head;
    logic              nv_valid;
    logic              nv_cfg;

    int                hold_left = 0;
    logic              held_once = 1'b0;
    rx_mode_t          rx_mode = RX_OPEN;
    int                rx_mode_left = 0;

    int                results_seen = 0;
    int                fail_count = 0;
    int                cycle_cnt = 0;
    tree_edge_t        got_expect;

    prim_mst_from_distance_matrix u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_distance    (i_distance),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_child       (o_child),
        .o_parent      (o_parent),
        .o_last_of_run (o_last_of_run),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic grow_tree(input int n);
        logic [NODE_W-1:0] order [MAX_NODES];
        logic [DIST_W-1:0] best_d [MAX_NODES];
        logic [NODE_W-1:0] best_p [MAX_NODES];
        logic [NODE_W-1:0] parent_of [MAX_NODES];
        logic [NODE_W-1:0] prev;
        logic [NODE_W-1:0] cand;
        logic [NODE_W-1:0] tmp_n;
        logic [DIST_W-1:0] d;
        logic [DIST_W-1:0] min_d;
        logic [DIST_W-1:0] tmp_d;
        int                p;
        int                i;
        int                min_i;
        tree_edge_t        e;
        for (i = 0; i < MAX_NODES; i++) begin
            order[i] = NODE_W'(i);
            best_d[i] = NO_DIST;
            best_p[i] = '0;
            parent_of[i] = '0;
        end
        for (p = 1; p < n; p++) begin
            prev = order[p-1];
            min_i = p;
            min_d = best_d[p];
            for (i = p; i < n; i++) begin
                cand = order[i];
                d = matrix_mem[int'(cand) * n + int'(prev)];
                if (d < best_d[i]) begin
                    best_d[i] = d;
                    best_p[i] = prev;
                end
                if (best_d[i] < min_d) begin
                    min_d = best_d[i];
                    min_i = i;
                end
            end
            tmp_n = order[p];  order[p] = order[min_i];  order[min_i] = tmp_n;
            tmp_d = best_d[p]; best_d[p] = best_d[min_i]; best_d[min_i] = tmp_d;
            tmp_n = best_p[p]; best_p[p] = best_p[min_i]; best_p[min_i] = tmp_n;
        end
        for (i = 0; i < n; i++)
            parent_of[order[i]] = best_p[i];
        for (i = 0; i < n; i++) begin
            e.child = NODE_W'(i);
            e.parent = parent_of[i];
            e.last = (i == n - 1);
            tree_expect_q.insert(tree_expect_q.size(), e);
        end
    endtask

    task automatic absorb_distance(input logic [DIST_W-1:0] d);
        int n;
        if (node_cfg == 0)
            n = 1;
        else if (node_cfg > MAX_NODES)
            n = MAX_NODES;
        else
            n = int'(node_cfg);
        matrix_mem[fill_pos] = d;
        fill_pos++;
        if (fill_pos >= n * n) begin
            fill_pos = 0;
            grow_tree(n);
        end
    endtask

    function automatic logic [DIST_W-1:0] draw_distance(input dist_mix_t mix);
        logic [DIST_W-1:0] v;
        case (mix)
            MIX_FULL:   v = $urandom();
            MIX_TIES:   v = $urandom_range(0, 3);
            MIX_SPARSE: v = ($urandom_range(0, 2) == 0) ? NO_DIST : DIST_W'($urandom_range(0, 1000));
            default:    v = NO_DIST - DIST_W'($urandom_range(0, 3));
        endcase
        return v;
    endfunction

    task automatic queue_value(input logic [DIST_W-1:0] v);
        feed_item_t f;
        f.kind = FEED_DIST;
        f.value = v;
        feed_q.insert(feed_q.size(), f);
    endtask

    task automatic queue_cfg(input int v);
        feed_item_t f;
        f.kind = FEED_CFG;
        f.value = DIST_W'(v);
        feed_q.insert(feed_q.size(), f);
    endtask

    task automatic queue_entries(input int count, input dist_mix_t mix);
        repeat (count) queue_value(draw_distance(mix));
    endtask

    // Prediction and configuration tracking at the accepting edge.
    always @(posedge i_clk) begin
        item_taken = i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_cfg_wr_en) begin
            node_cfg = i_cfg_wr_data;
            fill_pos = 0;
        end
        if (item_taken)
            absorb_distance(i_distance);
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (tree_expect_q.size() == 0 && !i_valid && !i_cfg_wr_en)
                quiet_cnt++;
            else
                quiet_cnt = 0;
            if (!(i_valid && !item_taken)) begin
                nv_valid = 1'b0;
                nv_cfg = 1'b0;
                if (feed_q.size() != 0) begin
                    if (feed_q[0].kind == FEED_CFG) begin
                        if (quiet_cnt >= SETTLE_CYCLES) begin
                            feed_head = feed_q.pop_front();
                            nv_cfg = 1'b1;
                            i_cfg_wr_data <= feed_head.value[CFG_W-1:0];
                            quiet_cnt = 0;
                        end
                    end else if (gap_left != 0) begin
                        gap_left--;
                    end else begin
                        feed_head = feed_q.pop_front();
                        nv_valid = 1'b1;
                        i_distance <= feed_head.value;
                        if (burst_left <= 1) begin
                            if ($urandom_range(0, 7) == 0) begin
                                burst_left = $urandom_range(32, 64);
                                gap_left = 0;
                            end else begin
                                burst_left = $urandom_range(1, 16);
                                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
                            end
                        end else begin
                            burst_left--;
                        end
                    end
                end
                i_valid <= nv_valid;
                i_cfg_wr_en <= nv_cfg;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (!held_once && o_valid && results_seen >= 10 && feed_q.size() != 0 &&
                     feed_q[0].kind == FEED_DIST) begin
            held_once = 1'b1;
            hold_left = LONG_HOLD - 1;
            i_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 2));
                rx_mode_left = $urandom_range(16, 64);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                RX_OPEN: i_ready <= 1'b1;
                RX_HALF: i_ready <= ($urandom_range(0, 1) == 0);
                default: i_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (tree_expect_q.size() == 0) begin
                $display("%0t: unexpected item child=%0d parent=%0d last=%0d",
                         $time, o_child, o_parent, o_last_of_run);
                fail_count++;
            end else begin
                got_expect = tree_expect_q.pop_front();
                if (o_child !== got_expect.child) begin
                    $display("%0t: child expected %0d actual %0d", $time, got_expect.child, o_child);
                    fail_count++;
                end
                if (o_parent !== got_expect.parent) begin
                    $display("%0t: parent of %0d expected %0d actual %0d",
                             $time, got_expect.child, got_expect.parent, o_parent);
                    fail_count++;
                end
                if (o_last_of_run !== got_expect.last) begin
                    $display("%0t: last_of_run of %0d expected %0d actual %0d",
                             $time, got_expect.child, got_expect.last, o_last_of_run);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int        n;
        int        eff;
        int        reps;
        int        cnt;
        int        random_count;
        dist_mix_t mix;

        // A node count of zero acts as a single node.
        queue_cfg(0);
        queue_value('0);
        queue_cfg(1);
        queue_value(NO_DIST);
        // An all-ones distance never replaces the initial best, so node 1 keeps parent 0.
        queue_cfg(2);
        queue_value('0);
        queue_value(32'd5);
        queue_value(NO_DIST);
        queue_value(32'd7);
        // Equal distances everywhere.
        queue_cfg(3);
        repeat (9) queue_value(32'd1);
        // Rewriting the node count in the middle of a load discards the partial matrix.
        queue_cfg(2);
        queue_value(NO_DIST - 1);
        queue_value(32'd1);
        queue_value(32'd2);
        queue_cfg(2);
        queue_value(32'd9);
        queue_value('0);
        queue_value('0);
        queue_value(NO_DIST);

        random_count = 0;
        while (random_count < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       n = $urandom_range(0, 1);
                1, 2:    n = $urandom_range(7, 12);
                default: n = $urandom_range(2, 6);
            endcase
            eff = (n == 0) ? 1 : n;
            queue_cfg(n);
            reps = $urandom_range(2, 4);
            repeat (reps) begin
                mix = dist_mix_t'($urandom_range(0, 3));
                if (eff > 1 && $urandom_range(0, 5) == 0) begin
                    cnt = $urandom_range(1, eff * eff - 1);
                    queue_entries(cnt, mix);
                    queue_cfg(n);
                    random_count += cnt;
                end
                queue_entries(eff * eff, mix);
                random_count += eff * eff;
            end
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while ((feed_q.size() != 0 || i_valid || i_cfg_wr_en || tree_expect_q.size() != 0) &&
               cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d items outstanding", $time, tree_expect_q.size());
            $display("status: fail");
        end else begin
            repeat (TAIL_CYCLES) @(posedge i_clk);
            if (tree_expect_q.size() != 0)
                $display("%0t: %0d expected items never arrived", $time, tree_expect_q.size());
            if (fail_count == 0 && tree_expect_q.size() == 0) begin
                $display("status: pass");
            end else begin
                $display("status: fail");
            end
        end
        $finish;
    end

endmodule
